// ----- rtl/core/ncle_pkg.sv -----
// ----------------------------------------------------------------------------
// ncle_pkg
// Shared types and constants of the noise channel: item layouts, command
// bundle between controller and datapath, register indexes and timing limits.
// ----------------------------------------------------------------------------
package ncle_pkg;

    // Timing base
    localparam int unsigned CPU_HZ       = 16777216;
    localparam int unsigned LENGTH_UNITS = 64;
    localparam int unsigned FREQ_BASE_R0 = 524288;
    localparam int unsigned FREQ_BASE    = 262144;

    // Datapath widths
    localparam int unsigned STEP_W      = 20;
    localparam int unsigned NOISE_CD_W  = 25;
    localparam int unsigned ENV_CD_W    = 23;
    localparam int unsigned LEN_CD_W    = 26;
    localparam int unsigned LEN_UNITS_W = 7;
    localparam int unsigned LFSR_W      = 16;
    localparam int unsigned NOISE_CD_MAX = (1 << NOISE_CD_W) - 1;

    // Noise clock table: 8 ratio codes by 16 shift codes
    localparam int unsigned RATIO_CODES = 8;
    localparam int unsigned SHIFT_CODES = 16;
    localparam int unsigned PERIOD_ENTRIES = RATIO_CODES * SHIFT_CODES;
    localparam int unsigned PERIOD_IDX_W = $clog2(PERIOD_ENTRIES);

    // Reset values
    localparam logic [LFSR_W-1:0] LFSR_RESET     = 16'hFFFF;
    localparam logic [STEP_W-1:0] ENV_STEP_RESET = 20'd262144;
    localparam logic [STEP_W-1:0] LEN_STEP_RESET = 20'd65536;
    localparam logic [3:0]        VOLUME_MAX     = 4'hF;

    // Configuration register indexes
    localparam int unsigned CFG_ADDR_W = 1;
    localparam logic [CFG_ADDR_W-1:0] REG_ENV_STEP = 1'd0;
    localparam logic [CFG_ADDR_W-1:0] REG_LEN_STEP = 1'd1;

    // Request kinds carried on tuser
    localparam logic OP_TICK  = 1'b0;
    localparam logic OP_WRITE = 1'b1;

    localparam int unsigned IN_TDATA_W  = 24;
    localparam int unsigned OUT_TDATA_W = 8;

    // Input request fields, lowest bit last
    typedef struct packed {
        logic       narrow_mode;
        logic [3:0] shift_select;
        logic [2:0] dividing_ratio;
        logic [5:0] initial_length;
        logic       length_enable;
        logic [2:0] envelope_pace;
        logic       envelope_increase;
        logic [3:0] initial_volume;
        logic       trigger;
    } in_item_t;

    // Result fields, lowest bit last
    typedef struct packed {
        logic [1:0] pad;
        logic       triggered;
        logic       silenced;
        logic [3:0] sample;
    } out_item_t;

    // Commands from controller to datapath
    typedef struct packed {
        logic                  load;
        logic                  cfg_we;
        logic [CFG_ADDR_W-1:0] cfg_addr;
        logic [STEP_W-1:0]     cfg_wdata;
    } ctrl_cmd_t;

endpackage

// ----- rtl/core/ncle_ctrl.sv -----
// ----------------------------------------------------------------------------
// ncle_ctrl
// Handshake controller: tracks the result register and issues load commands
// to the datapath whenever a request is taken.
// ----------------------------------------------------------------------------
module ncle_ctrl (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           in_valid,
    output logic                           in_ready,
    output logic                           out_valid,
    input  logic                           out_ready,
    input  logic                           cfg_we,
    input  logic [ncle_pkg::CFG_ADDR_W-1:0] cfg_addr,
    input  logic [ncle_pkg::STEP_W-1:0]     cfg_wdata,
    output ncle_pkg::ctrl_cmd_t            cmd
);
    import ncle_pkg::*;

    localparam logic ST_EMPTY = 1'b0;
    localparam logic ST_FULL  = 1'b1;

    logic state_reg;
    logic state_next;
    logic accept;

    // Take a request while the result slot is empty or being drained
    assign in_ready  = (state_reg == ST_EMPTY) || out_ready;
    assign accept    = in_valid && in_ready;
    assign out_valid = (state_reg == ST_FULL);

    // Slot state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_EMPTY:
            begin
                if (accept)
                    state_next = ST_FULL;
            end
            ST_FULL:
            begin
                if (out_ready && !accept)
                    state_next = ST_EMPTY;
            end
            default:
            begin
                state_next = ST_EMPTY;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= ST_EMPTY;
        else
            state_reg <= state_next;
    end

    // Command bundle
    always_comb
    begin
        cmd.load      = accept;
        cmd.cfg_we    = cfg_we;
        cmd.cfg_addr  = cfg_addr;
        cmd.cfg_wdata = cfg_wdata;
    end

endmodule

// ----- rtl/core/ncle_datapath.sv -----
// ----------------------------------------------------------------------------
// ncle_datapath
// Channel state and per-request update: countdowns, LFSR, envelope, length
// expiry, configuration registers and the result register.
// ----------------------------------------------------------------------------
module ncle_datapath (
    input  logic                              clk,
    input  logic                              rst_n,
    input  ncle_pkg::ctrl_cmd_t               cmd,
    input  logic                              op,
    input  ncle_pkg::in_item_t                item,
    output ncle_pkg::out_item_t               result
);
    import ncle_pkg::*;

    // Configuration registers
    logic [STEP_W-1:0] env_step_reg;
    logic [STEP_W-1:0] len_step_reg;

    // Channel state
    logic [LFSR_W-1:0]     lfsr_reg,      lfsr_next;
    logic [3:0]            volume_reg,    volume_next;
    logic                  env_up_reg,    env_up_next;
    logic [2:0]            pace_reg,      pace_next;
    logic [2:0]            ratio_reg,     ratio_next;
    logic [3:0]            shift_reg,     shift_next;
    logic                  narrow_reg,    narrow_next;
    logic                  noise_run_reg, noise_run_next;
    logic [NOISE_CD_W-1:0] noise_cd_reg,  noise_cd_next;
    logic                  env_run_reg,   env_run_next;
    logic [ENV_CD_W-1:0]   env_cd_reg,    env_cd_next;
    logic                  len_pend_reg,  len_pend_next;
    logic [LEN_CD_W-1:0]   len_cd_reg,    len_cd_next;
    logic                  expired_reg,   expired_next;

    // Result register
    out_item_t result_reg, result_next;

    // Helpers
    logic [NOISE_CD_W-1:0]  period_tbl [PERIOD_ENTRIES];
    logic [PERIOD_IDX_W-1:0] period_idx;
    logic [NOISE_CD_W-1:0]  period;
    logic [2:0]             pace_src;
    logic [ENV_CD_W-1:0]    env_prod;
    logic [ENV_CD_W-1:0]    env_load;
    logic [LEN_UNITS_W-1:0] len_units;
    logic [LEN_UNITS_W+STEP_W-1:0] len_prod;
    logic [LEN_CD_W-1:0]    len_load;
    logic                   is_write;
    logic                   len_fire;
    logic                   noise_fire;
    logic                   env_fire;

    // Build the noise period table from the clock constants
    for (genvar r = 0; r < RATIO_CODES; r++)
    begin : g_ratio
        for (genvar s = 0; s < SHIFT_CODES; s++)
        begin : g_shift
            localparam int unsigned DIVISOR  = ((r == 0) ? 1 : r) << s;
            localparam int unsigned FREQ_RAW = (r == 0) ? (FREQ_BASE_R0 >> s)
                                                        : (FREQ_BASE / DIVISOR);
            localparam int unsigned FREQ     = (FREQ_RAW == 0) ? 1 : FREQ_RAW;
            localparam int unsigned PER_RAW  = CPU_HZ / FREQ;
            localparam int unsigned PER      = (PER_RAW == 0) ? 1 :
                                               ((PER_RAW > NOISE_CD_MAX) ? NOISE_CD_MAX
                                                                         : PER_RAW);
            assign period_tbl[r * SHIFT_CODES + s] = NOISE_CD_W'(PER);
        end
    end

    // Advance the noise register by one step
    function automatic logic [LFSR_W-1:0] lfsr_advance(input logic [LFSR_W-1:0] cur,
                                                       input logic narrow);
        logic              fb;
        logic [LFSR_W-1:0] t;
        fb = cur[0] ^ cur[1];
        t  = {fb, cur[LFSR_W-2:0]};
        if (narrow)
            t[7] = fb;
        return {1'b0, t[LFSR_W-1:1]};
    endfunction

    assign is_write = (op == OP_WRITE);

    // Period lookup, envelope and length reload values
    always_comb
    begin
        period_idx = is_write ? {item.dividing_ratio, item.shift_select}
                              : {ratio_reg, shift_reg};
        period     = period_tbl[period_idx];
        pace_src   = is_write ? item.envelope_pace : pace_reg;
        env_prod   = ENV_CD_W'(pace_src) * ENV_CD_W'(env_step_reg);
        env_load   = (env_prod == '0) ? ENV_CD_W'(1) : env_prod;
        len_units  = LEN_UNITS_W'(LENGTH_UNITS) - LEN_UNITS_W'(item.initial_length);
        len_prod   = (LEN_UNITS_W+STEP_W)'(len_units) * (LEN_UNITS_W+STEP_W)'(len_step_reg);
        len_load   = (len_prod == '0) ? LEN_CD_W'(1) : len_prod[LEN_CD_W-1:0];
    end

    // Countdown expiry on a tick
    assign len_fire   = len_pend_reg  && (len_cd_reg   == LEN_CD_W'(1));
    assign noise_fire = noise_run_reg && (noise_cd_reg == NOISE_CD_W'(1));
    assign env_fire   = env_run_reg   && (env_cd_reg   == ENV_CD_W'(1));

    // Next channel state
    always_comb
    begin
        lfsr_next      = lfsr_reg;
        volume_next    = volume_reg;
        env_up_next    = env_up_reg;
        pace_next      = pace_reg;
        ratio_next     = ratio_reg;
        shift_next     = shift_reg;
        narrow_next    = narrow_reg;
        noise_run_next = noise_run_reg;
        noise_cd_next  = noise_cd_reg;
        env_run_next   = env_run_reg;
        env_cd_next    = env_cd_reg;
        len_pend_next  = len_pend_reg;
        len_cd_next    = len_cd_reg;
        expired_next   = expired_reg;

        if (is_write)
        begin
            // Store clock settings; restart on trigger
            ratio_next  = item.dividing_ratio;
            shift_next  = item.shift_select;
            narrow_next = item.narrow_mode;
            if (item.trigger)
            begin
                env_up_next    = item.envelope_increase;
                pace_next      = item.envelope_pace;
                volume_next    = item.initial_volume;
                expired_next   = 1'b0;
                noise_run_next = 1'b1;
                noise_cd_next  = period;
                env_run_next   = (item.envelope_pace != 3'd0);
                env_cd_next    = (item.envelope_pace != 3'd0) ? env_load : '0;
                len_pend_next  = item.length_enable;
                len_cd_next    = item.length_enable ? len_load : '0;
                lfsr_next      = LFSR_RESET;
            end
        end
        else
        begin
            // Decrement running countdowns
            if (len_pend_reg && (len_cd_reg != '0))
                len_cd_next = len_cd_reg - LEN_CD_W'(1);
            if (noise_run_reg && (noise_cd_reg != '0))
                noise_cd_next = noise_cd_reg - NOISE_CD_W'(1);
            if (env_run_reg && (env_cd_reg != '0))
                env_cd_next = env_cd_reg - ENV_CD_W'(1);

            // Length expiry first
            if (len_fire)
            begin
                expired_next  = 1'b1;
                len_pend_next = 1'b0;
            end

            // Noise step
            if (noise_fire)
            begin
                if (expired_next)
                    noise_run_next = 1'b0;
                else
                begin
                    lfsr_next     = lfsr_advance(lfsr_reg, narrow_reg);
                    noise_cd_next = period;
                end
            end

            // Envelope step, stopping at either end of the volume range or on expiry
            if (env_fire)
            begin
                priority if (expired_next)
                    env_run_next = 1'b0;
                else if (env_up_reg && (volume_reg < VOLUME_MAX))
                begin
                    volume_next = volume_reg + 4'd1;
                    env_cd_next = env_load;
                end
                else if (!env_up_reg && (volume_reg != 4'd0))
                begin
                    volume_next = volume_reg - 4'd1;
                    env_cd_next = env_load;
                end
                else
                    env_run_next = 1'b0;
            end
        end
    end

    // Result from the updated state
    always_comb
    begin
        result_next.pad       = '0;
        result_next.triggered = is_write && item.trigger;
        result_next.silenced  = expired_next;
        result_next.sample    = (expired_next || !lfsr_next[0]) ? 4'd0 : volume_next;
    end

    // Configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            env_step_reg <= ENV_STEP_RESET;
            len_step_reg <= LEN_STEP_RESET;
        end
        else if (cmd.cfg_we)
        begin
            unique case (cmd.cfg_addr)
                REG_ENV_STEP: env_step_reg <= cmd.cfg_wdata;
                REG_LEN_STEP: len_step_reg <= cmd.cfg_wdata;
                default:      ;
            endcase
        end
    end

    // Channel state registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            lfsr_reg      <= LFSR_RESET;
            volume_reg    <= '0;
            env_up_reg    <= 1'b0;
            pace_reg      <= '0;
            ratio_reg     <= '0;
            shift_reg     <= '0;
            narrow_reg    <= 1'b0;
            noise_run_reg <= 1'b0;
            noise_cd_reg  <= '0;
            env_run_reg   <= 1'b0;
            env_cd_reg    <= '0;
            len_pend_reg  <= 1'b0;
            len_cd_reg    <= '0;
            expired_reg   <= 1'b0;
        end
        else if (cmd.load)
        begin
            lfsr_reg      <= lfsr_next;
            volume_reg    <= volume_next;
            env_up_reg    <= env_up_next;
            pace_reg      <= pace_next;
            ratio_reg     <= ratio_next;
            shift_reg     <= shift_next;
            narrow_reg    <= narrow_next;
            noise_run_reg <= noise_run_next;
            noise_cd_reg  <= noise_cd_next;
            env_run_reg   <= env_run_next;
            env_cd_reg    <= env_cd_next;
            len_pend_reg  <= len_pend_next;
            len_cd_reg    <= len_cd_next;
            expired_reg   <= expired_next;
        end
    end

    // Hold the result until the next request is taken
    always_ff @(posedge clk)
    begin
        if (cmd.load)
            result_reg <= result_next;
    end

    assign result = result_reg;

endmodule

// ----- rtl/core/noise_channel_lfsr_envelope.sv -----
// ----------------------------------------------------------------------------
// noise_channel_lfsr_envelope
// Noise channel with 16-bit LFSR, volume envelope and length timer.
// ----------------------------------------------------------------------------
// Usage:
//   The slave stream carries one request per item: tuser selects a CPU-cycle
//   tick (0) or a control write (1); tdata carries the write fields. Every
//   request yields exactly one result on the master stream: the current
//   sample, the silenced flag and a flag marking a restarting write.
//   A result is registered and appears in the cycle after its request is
//   taken. Throughput is one request per cycle; the whole per-tick update
//   (countdowns, LFSR step, envelope step, reload products) is done in one
//   pass through the datapath, and the result register is reloaded as it
//   drains, so back-pressure only stops intake while a result waits unread.
//   The configuration port takes a write at any edge with cfg_we high;
//   write it only while no result is outstanding.
//   Reset (rst_n low, asynchronous) loads the LFSR with all ones, clears
//   volume, countdowns and flags, sets the step registers to their defaults
//   and marks the result register empty.
// ----------------------------------------------------------------------------
module noise_channel_lfsr_envelope (
    input  logic                                clk,
    input  logic                                rst_n,
    // tdata: trigger, initial_volume[4], envelope_increase, envelope_pace[3],
    //        length_enable, initial_length[6], dividing_ratio[3],
    //        shift_select[4], narrow_mode
    input  logic [ncle_pkg::IN_TDATA_W-1:0]     s_axis_tdata,
    // tuser: operation
    input  logic                                s_axis_tuser,
    input  logic                                s_axis_tvalid,
    output logic                                s_axis_tready,
    // tdata: sample[4], silenced, triggered, two zero bits
    output logic [ncle_pkg::OUT_TDATA_W-1:0]    m_axis_tdata,
    output logic                                m_axis_tvalid,
    input  logic                                m_axis_tready,
    input  logic                                cfg_we,
    input  logic [ncle_pkg::CFG_ADDR_W-1:0]     cfg_addr,
    input  logic [ncle_pkg::STEP_W-1:0]         cfg_wdata
);
    import ncle_pkg::*;

    ctrl_cmd_t cmd;
    in_item_t  item;
    out_item_t result;

    assign item = in_item_t'(s_axis_tdata);

    // Handshake control
    ncle_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (s_axis_tvalid),
        .in_ready  (s_axis_tready),
        .out_valid (m_axis_tvalid),
        .out_ready (m_axis_tready),
        .cfg_we    (cfg_we),
        .cfg_addr  (cfg_addr),
        .cfg_wdata (cfg_wdata),
        .cmd       (cmd)
    );

    // Channel datapath
    ncle_datapath u_datapath (
        .clk    (clk),
        .rst_n  (rst_n),
        .cmd    (cmd),
        .op     (s_axis_tuser),
        .item   (item),
        .result (result)
    );

    assign m_axis_tdata = OUT_TDATA_W'(result);

endmodule

// ----- rtl/core/ncle_checker.sv -----
// ----------------------------------------------------------------------------
// ncle_checker
// Port-level checks of the noise channel, bound to the top level.
// ----------------------------------------------------------------------------
module ncle_checker (
    input logic                             clk,
    input logic                             rst_n,
    input logic [ncle_pkg::IN_TDATA_W-1:0]  s_axis_tdata,
    input logic                             s_axis_tuser,
    input logic                             s_axis_tvalid,
    input logic                             s_axis_tready,
    input logic [ncle_pkg::OUT_TDATA_W-1:0] m_axis_tdata,
    input logic                             m_axis_tvalid,
    input logic                             m_axis_tready
);
    import ncle_pkg::*;

    logic in_acc;

    assign in_acc = s_axis_tvalid && s_axis_tready;

    // A stalled result holds
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
        else $error("result changed while stalled");

    // Every taken request shows a result in the next cycle
    a_result_follows: assert property (@(posedge clk) disable iff (!rst_n)
        in_acc |=> m_axis_tvalid)
        else $error("no result after request");

    // A restarting write reports triggered and not silenced
    a_trigger_result: assert property (@(posedge clk) disable iff (!rst_n)
        in_acc && (s_axis_tuser == OP_WRITE) && s_axis_tdata[0]
        |=> m_axis_tdata[5] && !m_axis_tdata[4])
        else $error("trigger result wrong");

    // A tick never reports triggered
    a_tick_result: assert property (@(posedge clk) disable iff (!rst_n)
        in_acc && (s_axis_tuser == OP_TICK) |=> !m_axis_tdata[5])
        else $error("tick reported trigger");

    // Silenced output carries a zero sample
    a_silent_zero: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && m_axis_tdata[4] |-> (m_axis_tdata[3:0] == 4'd0))
        else $error("sample while silenced");

endmodule

bind noise_channel_lfsr_envelope ncle_checker u_ncle_checker (
    .clk           (clk),
    .rst_n         (rst_n),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready)
);
